@@ design/gpss_pkg.sv @@
`timescale 1ns / 1ps

package gpss_pkg;

    // Fixed field widths of the ports.
    localparam int CFG_W       = 16;
    localparam int BASE_W      = 32;
    localparam int REQ_W       = 7;
    localparam int TCH_W       = 3;
    localparam int TST_W       = 4;
    localparam int GATES_W     = 8;
    localparam int OUT_STEP_W  = 4;

    // Rate multiplier: unsigned, 12 fraction bits, 1.0 after reset.
    localparam int              MULT_FRAC        = 12;
    localparam logic [CFG_W-1:0] RATE_MULT_RESET = 16'd4096;

    localparam int PROD_W = BASE_W + CFG_W;

    // One request as it waits in the first stage, with the increment product.
    typedef struct packed {
        logic                     run_level;
        logic                     reset_level;
        logic                     ext_connected;
        logic                     ext_clock_level;
        logic signed [REQ_W-1:0]  requested_steps;
        logic                     toggle_valid;
        logic [TCH_W-1:0]         toggle_channel;
        logic [TST_W-1:0]         toggle_step;
        logic [PROD_W-1:0]        product;
    } t_s1;

endpackage

@@ design/gate_pattern_step_sequencer_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_stall    run, reset, ext clock, increment, steps, toggle
// result    out        o_out_valid / i_out_stall  gates, current_step, is_running, advanced
// config    in         i_cfg_we                   i_cfg_wdata (rate multiplier)
//
// One request per cycle is sustained while i_out_stall is low; an accepted request is registered
// in stage 1, then in stage 2, and its result is held in the stage 3 output registers.
// Stage 1 registers the increment product, stage 2 updates the step state and reads the
// pattern memory (two read ports), stage 3 writes the toggled row back and holds the result.
// Reset is synchronous: the step state and run flags are restored and the per-row valid
// bits are cleared at once, so rows never written read as all gates off.
// A stalled result stage lets the earlier stages fill; the request side stalls only
// when all three stages hold a request.
module gate_pattern_step_sequencer_top
    import gpss_pkg::*;
#(
    parameter int STEP_COUNT    = 12,
    parameter int CHANNEL_COUNT = 8,
    parameter int PHASE_BITS    = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_wdata,

    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_run_level,
    input  logic                    i_reset_level,
    input  logic                    i_ext_connected,
    input  logic                    i_ext_clock_level,
    input  logic [BASE_W-1:0]       i_base_increment,
    input  logic signed [REQ_W-1:0] i_requested_steps,
    input  logic                    i_toggle_valid,
    input  logic [TCH_W-1:0]        i_toggle_channel,
    input  logic [TST_W-1:0]        i_toggle_step,

    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [GATES_W-1:0]      o_gates,
    output logic [OUT_STEP_W-1:0]   o_current_step,
    output logic                    o_is_running,
    output logic                    o_advanced
);

    localparam int SW         = $clog2(STEP_COUNT);
    localparam int SHIFT_UP   = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
    localparam int SHIFT_DOWN = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
    localparam logic [63:0]            PHASE_MAX = (64'd1 << PHASE_BITS) - 64'd1;
    localparam logic signed [REQ_W-1:0] STEP_S   = REQ_W'(STEP_COUNT);
    localparam logic [CHANNEL_COUNT-1:0] ONE_HOT0 = CHANNEL_COUNT'(1);

    // Configuration and architectural step state.
    logic [CFG_W-1:0]      r_rate_multiplier;
    logic [SW-1:0]         r_step_pos, n_step_pos;
    logic [PHASE_BITS-1:0] r_phase, n_phase;
    logic                  r_run, n_run;
    logic                  r_last_run, r_last_reset, r_last_ext, n_last_ext;

    // Pattern memory with a valid bit per row.
    logic [CHANNEL_COUNT-1:0] r_pattern [STEP_COUNT];
    logic [STEP_COUNT-1:0]    r_row_valid;

    // Pipeline registers.
    logic                     r1_valid;
    t_s1                      r1;
    logic                     r2_valid;
    logic [CHANNEL_COUNT-1:0] r2_row_a, r2_row_b;
    logic                     r2_tog_ok;
    logic [SW-1:0]            r2_tst;
    logic [TCH_W-1:0]         r2_tch;
    logic [SW-1:0]            r2_step;
    logic                     r2_running;
    logic                     r2_advanced;
    logic                     r_out_valid;

    logic en1, en2, en3, adv2;

    assign en3  = !r_out_valid || !i_out_stall;
    assign en2  = !r2_valid || en3;
    assign en1  = !r1_valid || en2;
    assign adv2 = en2 && r1_valid;
    assign o_in_stall = !en1;

    // ---------------- stage 2 logic: step state update ----------------
    logic [63:0]           inc_wide;
    logic [PHASE_BITS-1:0] inc;
    logic [PHASE_BITS:0]   phase_sum;
    logic                  run_rise, ext_rise, reset_rise, step_next;
    logic [SW:0]           step_limit, step_plus;
    logic                  tog_ok;
    logic [SW-1:0]         addr_a;

    assign inc_wide  = (64'(r1.product >> MULT_FRAC) >> SHIFT_DOWN) << SHIFT_UP;
    assign inc       = (inc_wide > PHASE_MAX) ? PHASE_MAX[PHASE_BITS-1:0]
                                              : inc_wide[PHASE_BITS-1:0];
    assign phase_sum = {1'b0, r_phase} + {1'b0, inc};

    assign run_rise   = r1.run_level && !r_last_run;
    assign reset_rise = r1.reset_level && !r_last_reset;
    assign ext_rise   = r1.ext_clock_level && !r_last_ext;

    always_comb begin
        if (r1.requested_steps < REQ_W'(signed'(1))) begin
            step_limit = (SW+1)'(1);
        end else if (r1.requested_steps > STEP_S) begin
            step_limit = (SW+1)'(STEP_COUNT);
        end else begin
            step_limit = (SW+1)'(r1.requested_steps);
        end
    end

    assign step_plus = (SW+1)'(r_step_pos) + (SW+1)'(1);

    always_comb begin
        n_run      = r_run ^ run_rise;
        n_phase    = r_phase;
        n_last_ext = r_last_ext;
        step_next  = 1'b0;
        if (n_run) begin
            if (r1.ext_connected) begin
                n_last_ext = r1.ext_clock_level;
                if (ext_rise) begin
                    n_phase   = '0;
                    step_next = 1'b1;
                end
            end else begin
                n_phase   = phase_sum[PHASE_BITS-1:0];
                step_next = phase_sum[PHASE_BITS];
            end
        end
        n_step_pos = r_step_pos;
        if (reset_rise) begin
            n_phase    = '0;
            step_next  = 1'b1;
            n_step_pos = '0;
        end else if (step_next) begin
            n_step_pos = (step_plus >= step_limit) ? '0 : step_plus[SW-1:0];
        end
    end

    assign tog_ok = r1.toggle_valid
                 && (32'(r1.toggle_channel) < CHANNEL_COUNT)
                 && (32'(r1.toggle_step) < STEP_COUNT);
    assign addr_a = tog_ok ? SW'(r1.toggle_step) : '0;

    // ---------------- stage 3 logic: write back and result ----------------
    logic                     w_en;
    logic [CHANNEL_COUNT-1:0] w_mask, w_data, row_b_eff;
    logic                     fwd_a, fwd_b;

    assign w_mask    = ONE_HOT0 << r2_tch;
    assign w_data    = r2_row_a ^ w_mask;
    assign w_en      = en3 && r2_valid && r2_tog_ok;
    // A write and a read of the same row at one edge: take the new row.
    assign fwd_a     = w_en && (r2_tst == addr_a);
    assign fwd_b     = w_en && (r2_tst == n_step_pos);
    assign row_b_eff = r2_row_b ^ ((r2_tog_ok && (r2_tst == r2_step)) ? w_mask : '0);

    logic [GATES_W-1:0] gate_bits;
    for (genvar g = 0; g < GATES_W; g++) begin : g_gates
        if (g < CHANNEL_COUNT) begin : g_on
            assign gate_bits[g] = row_b_eff[g];
        end else begin : g_off
            assign gate_bits[g] = 1'b0;
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_multiplier <= RATE_MULT_RESET;
            r_step_pos        <= '0;
            r_phase           <= '0;
            r_run             <= 1'b1;
            r_last_run        <= 1'b1;
            r_last_reset      <= 1'b1;
            r_last_ext        <= 1'b1;
            r_row_valid       <= '0;
            r1_valid          <= 1'b0;
            r2_valid          <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rate_multiplier <= i_cfg_wdata;
            end
            if (adv2) begin
                r_step_pos   <= n_step_pos;
                r_phase      <= n_phase;
                r_run        <= n_run;
                r_last_run   <= r1.run_level;
                r_last_reset <= r1.reset_level;
                r_last_ext   <= n_last_ext;
            end
            if (w_en) begin
                r_row_valid[r2_tst] <= 1'b1;
            end
            if (en1) begin
                r1_valid <= i_in_valid;
            end
            if (en2) begin
                r2_valid <= r1_valid;
            end
            if (en3) begin
                r_out_valid <= r2_valid;
            end
        end
    end

    // ---------------- payload registers and pattern memory ----------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pattern[r2_tst] <= w_data;
        end
        if (en1 && i_in_valid) begin
            r1.run_level       <= i_run_level;
            r1.reset_level     <= i_reset_level;
            r1.ext_connected   <= i_ext_connected;
            r1.ext_clock_level <= i_ext_clock_level;
            r1.requested_steps <= i_requested_steps;
            r1.toggle_valid    <= i_toggle_valid;
            r1.toggle_channel  <= i_toggle_channel;
            r1.toggle_step     <= i_toggle_step;
            r1.product         <= PROD_W'(i_base_increment) * PROD_W'(r_rate_multiplier);
        end
        if (adv2) begin
            if (fwd_a) begin
                r2_row_a <= w_data;
            end else if (r_row_valid[addr_a]) begin
                r2_row_a <= r_pattern[addr_a];
            end else begin
                r2_row_a <= '0;
            end
            if (fwd_b) begin
                r2_row_b <= w_data;
            end else if (r_row_valid[n_step_pos]) begin
                r2_row_b <= r_pattern[n_step_pos];
            end else begin
                r2_row_b <= '0;
            end
            r2_tog_ok   <= tog_ok;
            r2_tst      <= addr_a;
            r2_tch      <= r1.toggle_channel;
            r2_step     <= n_step_pos;
            r2_running  <= n_run;
            r2_advanced <= step_next;
        end
        if (en3 && r2_valid) begin
            o_gates        <= gate_bits;
            o_current_step <= OUT_STEP_W'(r2_step);
            o_is_running   <= r2_running;
            o_advanced     <= r2_advanced;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_step_pos) < STEP_COUNT)
        else $error("step position beyond the step count");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r1_valid && r2_valid && r_out_valid && i_out_stall))
        else $error("request stalled while the pipeline has room");

    a_write_marks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |=> r_row_valid[$past(r2_tst)])
        else $error("written row not marked valid");

    a_reset_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv2 && reset_rise) |=> (r_step_pos == '0 && r_phase == '0 && r2_advanced))
        else $error("reset edge did not restart the sequence");
`endif

endmodule
